// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the response checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on clk, off during reset.
`define MBRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define MBRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types, codes and the CRC-16 lookup table for the Modbus response checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] POS_ADDRESS  = 8'd0;
    localparam logic [7:0] POS_FUNCTION = 8'd1;
    localparam logic [7:0] POS_COUNT    = 8'd2;
    localparam logic [7:0] POS_CRC_MIN  = 8'd4;
    localparam logic [7:0] POS_SAT      = 8'hFF;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_FUNCTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNPACK_ENABLE     = 2'd2;

    localparam logic [7:0] RST_EXPECTED_ADDRESS  = 8'd1;
    localparam logic [6:0] RST_EXPECTED_FUNCTION = 7'd3;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_ADDR_MISMATCH = 3'd1,
        STATUS_FUNC_MISMATCH = 3'd2,
        STATUS_EXCEPTION    = 3'd3,
        STATUS_CRC_ERROR    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } rx_item_t;

    typedef struct packed {
        logic        word_valid;
        logic [5:0]  word_index;
        logic [15:0] word_value;
        logic        frame_done;
        status_t     status;
        logic [7:0]  exception_code;
    } result_t;

    typedef struct packed {
        logic [7:0] expected_address;
        logic [6:0] expected_function;
        logic       unpack_enable;
    } cfg_t;

    // Reflected CRC-16 table, one entry per low byte of (crc ^ data).
    function automatic logic [255:0][15:0] build_crc_table();
        logic [255:0][15:0] tbl;
        logic [15:0]        c;
        for (int i = 0; i < 256; i++)
        begin
            c = 16'(i);
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam logic [255:0][15:0] CRC_TABLE = build_crc_table();

endpackage

// File: rtl/modbus_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_response_checker
// Checks a Modbus RTU response byte by byte and unpacks its register words.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item): one received byte per
//   item, last_byte set on the final byte of the frame.
//   result channel (result_valid/result_ready/result_item): one item for each
//   completed register word and one for the last byte (both may share one).
//   Bytes that finish nothing produce no item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while no frame bytes are in flight.
//   Path: a byte taken into the input register goes through the single
//   CRC-table / check stage into the result register.
//   Throughput: one byte per cycle while nothing stalls, set by that one update stage.
//   Stall: while the result register is full and not taken, a byte that
//   would produce an item waits in the input register and byte_ready drops;
//   bytes that produce nothing still pass.
//   Reset: frame state cleared, CRC at 0xFFFF, registers back to address 1,
//   function 3, unpacking on. Frame state also clears after each last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_response_checker #(
    parameter int MAX_WORDS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             byte_valid,
    output logic                             byte_ready,
    input  mbrc_pkg::rx_item_t               byte_item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output mbrc_pkg::result_t                result_item
);

    mbrc_pkg::cfg_t     cfg;
    mbrc_pkg::rx_item_t byte_item_reg;
    logic               byte_valid_reg, byte_valid_next;
    mbrc_pkg::result_t  result_reg, core_result;
    logic               result_valid_reg, result_valid_next;
    logic               core_emit;
    logic               stage_fire;

    assign cfg_ready = 1'b1;

    mbrc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mbrc_core #(
        .MAX_WORDS (MAX_WORDS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (byte_item_reg),
        .fire   (stage_fire),
        .emit   (core_emit),
        .result (core_result)
    );

    always_comb
    begin
        stage_fire = byte_valid_reg && (!core_emit || !result_valid_reg || result_ready);
        byte_ready = !byte_valid_reg || stage_fire;

        byte_valid_next = byte_ready ? byte_valid : byte_valid_reg;

        if (stage_fire && core_emit)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg   <= byte_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            byte_item_reg <= byte_item;
        if (stage_fire && core_emit)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    `MBRC_ASSERT_NEXT(a_stage_hold, byte_valid_reg && !stage_fire,
        byte_valid_reg && $stable(byte_item_reg), "blocked byte lost")
    `MBRC_ASSERT(a_result_has_cause,
        result_valid_reg |-> result_reg.word_valid || result_reg.frame_done,
        "empty result item")
    `MBRC_ASSERT(a_idle_word_zero,
        result_valid_reg && !result_reg.word_valid |->
            result_reg.word_index == 6'd0 && result_reg.word_value == 16'h0000,
        "word fields set without word")

endmodule

// File: rtl/mbrc_cfg.sv
// ----------------------------------------------------------------------------
// mbrc_cfg
// Configuration registers of the response checker.
// ----------------------------------------------------------------------------
module mbrc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mbrc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [7:0]                     wr_data,
    output mbrc_pkg::cfg_t                 cfg
);

    mbrc_pkg::cfg_t cfg_reg;
    mbrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                mbrc_pkg::CFG_EXPECTED_ADDRESS:  cfg_next.expected_address  = wr_data;
                mbrc_pkg::CFG_EXPECTED_FUNCTION: cfg_next.expected_function = wr_data[6:0];
                mbrc_pkg::CFG_UNPACK_ENABLE:     cfg_next.unpack_enable     = wr_data[0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_address  <= mbrc_pkg::RST_EXPECTED_ADDRESS;
            cfg_reg.expected_function <= mbrc_pkg::RST_EXPECTED_FUNCTION;
            cfg_reg.unpack_enable     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/mbrc_core.sv
// ----------------------------------------------------------------------------
// mbrc_core
// Per-byte frame state: CRC, position, header checks, word assembly, status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbrc_core #(
    parameter int MAX_WORDS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbrc_pkg::cfg_t     cfg,
    input  mbrc_pkg::rx_item_t item,
    input  logic               fire,
    output logic               emit,
    output mbrc_pkg::result_t  result
);

    localparam logic [7:0] MAX_WORDS_W = 8'(MAX_WORDS);

    logic [7:0]  pos_reg,      pos_next;
    logic [15:0] crc_reg,      crc_next;
    logic        addr_ok_reg,  addr_ok_next;
    logic        func_ok_reg,  func_ok_next;
    logic        exc_reg,      exc_next;
    logic [7:0]  count_reg,    count_next;
    logic [7:0]  pending_reg,  pending_next;

    logic [15:0]           crc_upd;
    logic                  is_addr, is_func, is_count, is_body;
    logic [6:0]            word_idx;
    logic                  word_hit;
    mbrc_pkg::status_t     st;

    always_comb
    begin
        crc_upd = {8'h00, crc_reg[15:8]}
                ^ mbrc_pkg::CRC_TABLE[crc_reg[7:0] ^ item.rx_byte];

        is_addr  = (pos_reg == mbrc_pkg::POS_ADDRESS);
        is_func  = (pos_reg == mbrc_pkg::POS_FUNCTION);
        is_count = (pos_reg == mbrc_pkg::POS_COUNT);
        is_body  = !is_addr && !is_func && !is_count && (pos_reg != mbrc_pkg::POS_SAT);

        // word i completes at byte 4+2i
        word_idx = pos_reg[7:1] - 7'd2;
        word_hit = is_body && !pos_reg[0] && cfg.unpack_enable && !exc_reg
                 && (word_idx < count_reg[7:1])
                 && ({1'b0, word_idx} < MAX_WORDS_W);

        addr_ok_next = is_addr  ? (item.rx_byte == cfg.expected_address) : addr_ok_reg;
        func_ok_next = is_func  ? (item.rx_byte[6:0] == cfg.expected_function) : func_ok_reg;
        exc_next     = is_func  ? item.rx_byte[7] : exc_reg;
        count_next   = is_count ? item.rx_byte : count_reg;
        pending_next = (is_body && pos_reg[0]) ? item.rx_byte : pending_reg;
        crc_next     = crc_upd;
        pos_next     = (pos_reg != mbrc_pkg::POS_SAT) ? pos_reg + 8'd1 : pos_reg;

        if (!addr_ok_next)
            st = mbrc_pkg::STATUS_ADDR_MISMATCH;
        else if (!func_ok_next)
            st = mbrc_pkg::STATUS_FUNC_MISMATCH;
        else if (exc_next)
            st = mbrc_pkg::STATUS_EXCEPTION;
        else if ((pos_reg >= mbrc_pkg::POS_CRC_MIN) && (crc_upd != 16'h0000))
            st = mbrc_pkg::STATUS_CRC_ERROR;
        else
            st = mbrc_pkg::STATUS_OK;

        emit = word_hit || item.last_byte;

        result.word_valid     = word_hit;
        result.word_index     = word_hit ? word_idx[5:0] : 6'd0;
        result.word_value     = word_hit ? {pending_reg, item.rx_byte} : 16'h0000;
        result.frame_done     = item.last_byte;
        result.status         = item.last_byte ? st : mbrc_pkg::STATUS_OK;
        result.exception_code = (item.last_byte && st == mbrc_pkg::STATUS_EXCEPTION)
                              ? count_next : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 8'd0;
            crc_reg     <= mbrc_pkg::CRC_INIT;
            addr_ok_reg <= 1'b0;
            func_ok_reg <= 1'b0;
            exc_reg     <= 1'b0;
            count_reg   <= 8'd0;
            pending_reg <= 8'd0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                pos_reg     <= 8'd0;
                crc_reg     <= mbrc_pkg::CRC_INIT;
                addr_ok_reg <= 1'b0;
                func_ok_reg <= 1'b0;
                exc_reg     <= 1'b0;
                count_reg   <= 8'd0;
                pending_reg <= 8'd0;
            end
            else
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                addr_ok_reg <= addr_ok_next;
                func_ok_reg <= func_ok_next;
                exc_reg     <= exc_next;
                count_reg   <= count_next;
                pending_reg <= pending_next;
            end
        end
    end

    `MBRC_ASSERT_NEXT(a_frame_restart, fire && item.last_byte,
        pos_reg == 8'd0 && crc_reg == mbrc_pkg::CRC_INIT, "frame state not cleared")
    `MBRC_ASSERT(a_status_only_at_end,
        !item.last_byte |-> result.status == mbrc_pkg::STATUS_OK, "status off frame end")

endmodule
